FILE: rtl/core/ile_pkg.sv
// Shared types and constants of the indexed list engine.
package ile_pkg;

  // Default storage shape.
  localparam int unsigned CapacityDefault  = 16;
  localparam int unsigned DataWidthDefault = 32;

  // Request opcodes; the two codes above clear are ignored.
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_FIND   = 3'd2,
    OP_READ   = 3'd3,
    OP_APPEND = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_WRITE,
    SEQ_DONE
  } seq_state_e;

  // Request word.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  position;
    logic [31:0] value;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic        found;
    logic [3:0]  match_position;
    logic [4:0]  entry_count;
  } rsp_t;

  // Finished result offered by the sequencer to the output register.
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } rsp_hs_t;

endpackage

FILE: rtl/core/indexed_list_engine_unit.sv
// Top level of the indexed list engine: sequencer, entry RAM and output register.
//
//   Channel   Direction  Handshake                Word
//   request   in         req_valid_i/req_ready_o  req_i (opcode, position, value)
//   result    out        rsp_valid_o/rsp_ready_i  rsp_o (status, data, found, match, count)
//
// One request at a time. Rejected requests, clear, unused opcodes, find on an empty list
// and erase of the last entry go straight to the result; append and insert at the end
// write one entry, and read fetches one entry. Insert elsewhere moves entries up and then
// writes the new one, erase elsewhere moves entries down, and find compares entries up
// to a hit, set by the single RAM read port streaming one entry a cycle. Reset empties
// the list at once; entry storage is not cleared.
// A result waiting at the output does not stop the next request from being taken.
module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int unsigned Capacity  = CapacityDefault,
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(Capacity);

  rsp_hs_t              seq_rsp;
  logic                 out_ready;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DataWidth-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [DataWidth-1:0] ram_rdata;

  // Request decode and entry streaming.
  ile_seq #(
    .Capacity  (Capacity),
    .DataWidth (DataWidth)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_o       (seq_rsp),
    .rsp_ready_i (out_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // List entries.
  ile_ram #(
    .Width (DataWidth),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result word register.
  ile_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (seq_rsp),
    .in_ready_o  (out_ready),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: rtl/core/ile_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ile_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ile_outreg.sv
// Output register that holds one finished result word until it is taken.
module ile_outreg
  import ile_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rsp_hs_t in_i,
  output logic    in_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  output rsp_t    rsp_o
);

  logic valid_q, valid_d;
  rsp_t data_q;
  logic load;

  // The register takes a new word when empty or when its word leaves now.
  assign in_ready_o = !valid_q || rsp_ready_i;
  assign load       = in_i.valid && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_i.rsp;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o       = data_q;

endmodule

FILE: rtl/core/ile_seq.sv
// Sequencer: decodes a request, streams list entries through the RAM and builds the result.
module ile_seq
  import ile_pkg::*;
#(
  parameter int unsigned Capacity  = CapacityDefault,
  parameter int unsigned DataWidth = DataWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  req_t                        req_i,
  output rsp_hs_t                     rsp_o,
  input  logic                        rsp_ready_i,
  output logic                        ram_we_o,
  output logic [$clog2(Capacity)-1:0] ram_waddr_o,
  output logic [DataWidth-1:0]        ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(Capacity)-1:0] ram_raddr_o,
  input  logic [DataWidth-1:0]        ram_rdata_i
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  seq_state_e state_q, state_d;

  // Control registers.
  logic [CW-1:0] cnt_q, cnt_d;
  logic          iss_q, iss_d;
  logic          pend_q, pend_d;

  // Working registers of the current request.
  logic [2:0]           op_q, op_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [DataWidth-1:0] val_q, val_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        end_q, end_d;
  logic                 up_q, up_d;
  logic [AW-1:0]        paddr_q, paddr_d;
  status_e              status_q, status_d;
  logic [DataWidth-1:0] rdata_q, rdata_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        mpos_q, mpos_d;

  // Decode of an incoming request.
  seq_state_e    dec_state;
  status_e       dec_status;
  logic [CW-1:0] dec_cnt;
  logic [AW-1:0] dec_pos;
  logic [AW-1:0] dec_idx;
  logic [AW-1:0] dec_end;
  logic          dec_up;
  logic [31:0]   pos_w;
  logic [31:0]   cnt_w;

  logic accept;
  logic scan_last;
  logic find_hit;
  logic scan_done;

  assign accept = (state_q == SEQ_IDLE) && req_valid_i;

  // Returned read data: last entry of the scan, or a hit for find.
  assign scan_last = pend_q && (paddr_q == end_q);
  assign find_hit  = pend_q && (op_q == OP_FIND) &&
                     (ram_rdata_i == val_q);
  assign scan_done = scan_last || find_hit;

  // Work out the range and capacity checks and the scan span for a request.
  always_comb begin
    pos_w      = 32'(req_i.position);
    cnt_w      = 32'(cnt_q);
    dec_state  = SEQ_DONE;
    dec_status = ST_OK;
    dec_cnt    = cnt_q;
    dec_pos    = AW'(req_i.position);
    dec_idx    = '0;
    dec_end    = '0;
    dec_up     = 1'b1;
    unique case (req_i.opcode)
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          dec_status = ST_RANGE;
        end else if (cnt_w >= 32'(Capacity)) begin
          dec_status = ST_FULL;
        end else if (pos_w == cnt_w) begin
          dec_state = SEQ_WRITE;
        end else begin
          dec_state = SEQ_SCAN;
          dec_idx   = AW'(cnt_q - CW'(1));
          dec_end   = AW'(req_i.position);
          dec_up    = 1'b0;
        end
      end
      OP_ERASE: begin
        if (pos_w >= cnt_w) begin
          dec_status = ST_RANGE;
        end else if (pos_w + 32'd1 == cnt_w) begin
          dec_cnt = cnt_q - CW'(1);
        end else begin
          dec_state = SEQ_SCAN;
          dec_idx   = AW'(pos_w + 32'd1);
          dec_end   = AW'(cnt_q - CW'(1));
        end
      end
      OP_FIND: begin
        if (cnt_q != '0) begin
          dec_state = SEQ_SCAN;
          dec_end   = AW'(cnt_q - CW'(1));
        end
      end
      OP_READ: begin
        if (pos_w >= cnt_w) begin
          dec_status = ST_RANGE;
        end else begin
          dec_state = SEQ_SCAN;
          dec_idx   = AW'(req_i.position);
          dec_end   = AW'(req_i.position);
        end
      end
      OP_APPEND: begin
        if (cnt_w >= 32'(Capacity)) begin
          dec_status = ST_FULL;
        end else begin
          dec_state = SEQ_WRITE;
          dec_pos   = AW'(cnt_q);
        end
      end
      OP_CLEAR: begin
        dec_cnt = '0;
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (req_valid_i) begin
          state_d = dec_state;
        end
      end
      SEQ_SCAN: begin
        if (scan_done) begin
          state_d = (op_q == OP_INSERT) ? SEQ_WRITE : SEQ_DONE;
        end
      end
      SEQ_WRITE: begin
        state_d = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (rsp_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Register updates of the datapath.
  always_comb begin
    cnt_d    = cnt_q;
    iss_d    = 1'b0;
    pend_d   = 1'b0;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    idx_d    = idx_q;
    end_d    = end_q;
    up_d     = up_q;
    paddr_d  = paddr_q;
    status_d = status_q;
    rdata_d  = rdata_q;
    found_d  = found_q;
    mpos_d   = mpos_q;
    if (accept) begin
      cnt_d    = dec_cnt;
      iss_d    = (dec_state == SEQ_SCAN);
      op_d     = req_i.opcode;
      pos_d    = dec_pos;
      val_d    = DataWidth'(req_i.value);
      idx_d    = dec_idx;
      end_d    = dec_end;
      up_d     = dec_up;
      status_d = dec_status;
      rdata_d  = '0;
      found_d  = 1'b0;
      mpos_d   = '0;
    end else if (state_q == SEQ_SCAN) begin
      // Issue the next read while handling the word that returns now.
      if (iss_q) begin
        paddr_d = idx_q;
        iss_d   = (idx_q != end_q);
        if (idx_q != end_q) begin
          idx_d = up_q ? idx_q + AW'(1) : idx_q - AW'(1);
        end
      end
      pend_d = iss_q && !scan_done;
      if (pend_q && (op_q == OP_READ)) begin
        rdata_d = ram_rdata_i;
      end
      if (find_hit) begin
        found_d = 1'b1;
        mpos_d  = paddr_q;
      end
      if (scan_last && (op_q == OP_ERASE)) begin
        cnt_d = cnt_q - CW'(1);
      end
    end else if (state_q == SEQ_WRITE) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  // Outputs: handshake, RAM ports and the result word.
  always_comb begin
    req_ready_o = (state_q == SEQ_IDLE);
    ram_re_o    = (state_q == SEQ_SCAN) && iss_q;
    ram_raddr_o = idx_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = val_q;
    if (state_q == SEQ_SCAN && pend_q) begin
      if (op_q == OP_INSERT) begin
        ram_we_o    = 1'b1;
        ram_waddr_o = paddr_q + AW'(1);
        ram_wdata_o = ram_rdata_i;
      end else if (op_q == OP_ERASE) begin
        ram_we_o    = 1'b1;
        ram_waddr_o = paddr_q - AW'(1);
        ram_wdata_o = ram_rdata_i;
      end
    end else if (state_q == SEQ_WRITE) begin
      ram_we_o = 1'b1;
    end
    rsp_o.valid              = (state_q == SEQ_DONE);
    rsp_o.rsp.status         = status_q;
    rsp_o.rsp.read_data      = 32'(rdata_q);
    rsp_o.rsp.found          = found_q;
    rsp_o.rsp.match_position = 4'(mpos_q);
    rsp_o.rsp.entry_count    = 5'(cnt_q);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cnt_q   <= '0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    end_q    <= end_d;
    up_q     <= up_d;
    paddr_q  <= paddr_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
    found_q  <= found_d;
    mpos_q   <= mpos_d;
  end

endmodule

FILE: bench/tb_indexed_list_engine_unit.sv
// Testbench for the indexed list engine: directed and random list requests checked against a shadow list.
module tb_indexed_list_engine_unit;
  import ile_pkg::*;

  localparam int          ListDepth     = CapacityDefault;
  localparam logic [2:0]  OpSpareLo     = 3'd6;
  localparam logic [2:0]  OpSpareHi     = 3'd7;
  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned ItemsPerPhase = 430;
  localparam int unsigned MaxShown      = 10;
  localparam int unsigned PoolSize      = 8;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i       = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  // Request words waiting to be sent, and result words owed by the block.
  req_t req_words_q[$];
  rsp_t owed_rsp_q[$];

  // Shadow copy of the list.
  logic [31:0] list_mem [ListDepth];
  int          list_len = 0;

  // Fill level seen by the stimulus side, used to aim positions.
  int          fill_level = 0;
  logic [31:0] value_pool [PoolSize];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        req_taken      = 1'b0;

  int unsigned n_reqs     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_full     = 0;
  int unsigned n_range    = 0;
  int unsigned n_hits     = 0;
  int unsigned cycle_count = 0;

  indexed_list_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request word to the shadow list and work out its result word.
  task automatic apply_list_op(input req_t r, output rsp_t res);
    int pos;
    int i;
    res        = '0;
    res.status = ST_OK;
    pos        = int'(r.position);
    case (r.opcode)
      OP_INSERT: begin
        if (pos > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos] = r.value;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < list_len; i++) begin
          if (!res.found && list_mem[i] == r.value) begin
            res.found          = 1'b1;
            res.match_position = 4'(i);
          end
        end
      end
      OP_READ: begin
        if (pos >= list_len) res.status = ST_RANGE;
        else res.read_data = list_mem[pos];
      end
      OP_APPEND: begin
        if (list_len >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = r.value;
          list_len++;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.entry_count = 5'(list_len);
  endtask

  task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
    n_mismatch++;
    if (n_mismatch <= MaxShown) begin
      $display("%0t: %s", $time, what);
      $display("  expected status=%0d data=%h found=%0d match=%0d count=%0d",
               want.status, want.read_data, want.found, want.match_position,
               want.entry_count);
      $display("  actual   status=%0d data=%h found=%0d match=%0d count=%0d",
               got.status, got.read_data, got.found, got.match_position,
               got.entry_count);
    end
  endtask

  // Compare a result word with the oldest one owed.
  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (owed_rsp_q.size() == 0) begin
      flag_mismatch("result word with nothing outstanding", '0, got);
    end else begin
      want = owed_rsp_q.pop_front();
      n_checked++;
      if (got.status !== want.status || got.read_data !== want.read_data ||
          got.found !== want.found || got.match_position !== want.match_position ||
          got.entry_count !== want.entry_count) begin
        flag_mismatch("result word mismatch", want, got);
      end
    end
  endtask

  // Request driver and result acceptor; inputs change on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_valid_i || req_taken) begin
        if (req_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid_i <= 1'b1;
          req_i       <= req_words_q.pop_front();
        end else begin
          req_valid_i <= 1'b0;
        end
      end
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict for the request taken on this edge.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      req_taken <= req_valid_i && req_ready_o;
      if (rsp_valid_o && rsp_ready_i) check_result(rsp_o);
      if (req_valid_i && req_ready_o) begin
        apply_list_op(req_i, want);
        owed_rsp_q = {owed_rsp_q, want};
        n_reqs++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
        if (want.found) n_hits++;
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results owed", cycle_count,
               owed_rsp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Queue one request word and track the fill level it leads to.
  task automatic queue_req(input logic [2:0] op, input logic [4:0] pos, input logic [31:0] val);
    req_t w;
    w.opcode   = op;
    w.position = pos;
    w.value    = val;
    req_words_q = {req_words_q, w};
    case (op)
      OP_INSERT: if (int'(pos) <= fill_level && fill_level < ListDepth) fill_level++;
      OP_ERASE:  if (int'(pos) < fill_level) fill_level--;
      OP_APPEND: if (fill_level < ListDepth) fill_level++;
      OP_CLEAR:  fill_level = 0;
      default: ;
    endcase
  endtask

  // Random request; the mix alternates between growing and shrinking the list.
  task automatic queue_random_req(input bit shrink);
    int unsigned roll;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    roll = $urandom_range(99);
    if (roll < (shrink ? 15 : 25)) op = OP_INSERT;
    else if (roll < (shrink ? 55 : 45)) op = OP_ERASE;
    else if (roll < (shrink ? 70 : 60)) op = OP_FIND;
    else if (roll < (shrink ? 85 : 75)) op = OP_READ;
    else if (roll < 95) op = OP_APPEND;
    else if (roll < 97) op = OP_CLEAR;
    else op = $urandom_range(1) ? OpSpareHi : OpSpareLo;
    // Mostly positions inside or just past the live range, sometimes anywhere.
    if ($urandom_range(99) < 85) pos = 5'($urandom_range(fill_level));
    else pos = 5'($urandom_range(31));
    // A small value pool makes finds hit and duplicates appear.
    if ($urandom_range(99) < 75) val = value_pool[$urandom_range(PoolSize - 1)];
    else val = $urandom();
    queue_req(op, pos, val);
  endtask

  // Hold the sender until every queued word is sent and every result is back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_words_q.size() != 0 || req_valid_i || owed_rsp_q.size() != 0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < ItemsPerPhase; n++) queue_random_req(((n / 40) % 2) == 1);
    wait_drained();
  endtask

  initial begin
    int k;
    for (k = 0; k < PoolSize; k++) value_pool[k] = $urandom();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: every position is out of range, find misses, clear is harmless.
    queue_req(OP_READ, 5'd0, 32'h0);
    queue_req(OP_ERASE, 5'd0, 32'h0);
    queue_req(OP_FIND, 5'd0, 32'h0);
    queue_req(OP_CLEAR, 5'd0, 32'h0);
    queue_req(OP_INSERT, 5'd1, 32'h1);
    // Fill to capacity, with the value extremes and an insert in the middle.
    queue_req(OP_INSERT, 5'd0, 32'h0);
    queue_req(OP_APPEND, 5'd0, 32'hFFFF_FFFF);
    queue_req(OP_INSERT, 5'd1, 32'hA5A5_5A5A);
    for (k = 0; k < ListDepth - 3; k++) queue_req(OP_APPEND, 5'($urandom_range(31)), $urandom());
    // Full list: full status, and a bad insert position wins over full.
    queue_req(OP_INSERT, 5'd5, 32'h1234_5678);
    queue_req(OP_APPEND, 5'd0, 32'h8765_4321);
    queue_req(OP_INSERT, 5'd17, 32'h0);
    queue_req(OP_FIND, 5'd0, 32'hFFFF_FFFF);
    queue_req(OP_FIND, 5'd31, 32'h0000_0001);
    queue_req(OP_READ, 5'd15, 32'h0);
    queue_req(OP_READ, 5'd16, 32'h0);
    queue_req(OP_ERASE, 5'd31, 32'h0);
    queue_req(OP_ERASE, 5'd0, 32'h0);
    queue_req(OpSpareLo, 5'd3, 32'h0000_1234);
    queue_req(OpSpareHi, 5'd31, 32'hFFFF_FFFF);
    wait_drained();

    // Random traffic under each idling pattern.
    run_phase(0, 0);
    run_phase(64, 0);
    run_phase(0, 64);
    run_phase(7, 7);

    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d result words for %0d requests in four idling phases.",
             n_checked, n_reqs);
    $display("Saw %0d full and %0d out-of-range statuses and %0d find hits.",
             n_full, n_range, n_hits);
    if (n_mismatch == 0 && owed_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_mismatch, owed_rsp_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ile_pkg.sv
rtl/core/ile_ram.sv
rtl/core/ile_outreg.sv
rtl/core/ile_seq.sv
rtl/core/indexed_list_engine_unit.sv
bench/tb_indexed_list_engine_unit.sv
